FILE: design/grpe_pkg.sv
`default_nettype none
package grpe_pkg;

  // fixed field widths
  localparam int unsigned ROW_BITS_W = 8;
  localparam int unsigned COORD_IN_W = 10;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned GW_W       = 4;
  localparam int unsigned GH_W       = 5;
  localparam int unsigned HEFF_W     = 6;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned COL_W      = 3;
  localparam int unsigned WDIM_W     = 5;
  localparam int unsigned HDIM_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd4;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_INVERTED = 2'd1,
    MODE_DOUBLE   = 2'd2,
    MODE_TRANSP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_WINDOW = 2'd0,
    KIND_STREAM = 2'd1,
    KIND_ADDR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_WIN  = 2'd1,
    BK_PIX  = 2'd2
  } bk_state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
    mode_t              mode;
    logic [GW_W-1:0]    gw;
    logic [GH_W-1:0]    gh;
  } cfg_t;

  // one classified row, handed from front to back
  typedef struct packed {
    logic [ROW_BITS_W-1:0] bits;
    logic [COORD_IN_W-1:0] cx;
    logic [COORD_IN_W-1:0] cy;
    logic [ROW_W-1:0]      row;
    logic [GW_W-1:0]       w;
    logic [WDIM_W-1:0]     wdim;
    logic [HDIM_W-1:0]     hdim;
    logic [COORD_W-1:0]    ncx;
    logic [COLOR_W-1:0]    on_color;
    logic [COLOR_W-1:0]    off_color;
    mode_t                 mode;
    logic                  first;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [WDIM_W-1:0]  win_width;
    logic [HDIM_W-1:0]  win_height;
    logic [COLOR_W-1:0] pixel_color;
    logic [COORD_W-1:0] next_cursor_x;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

FILE: design/grpe_queue.sv
`default_nettype none
module grpe_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire grpe_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               nonempty,
  output grpe_pkg::cmd_t     head
);

  grpe_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign nonempty = (count_r != 2'd0);
  assign head     = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: design/grpe_front.sv
`default_nettype none
module grpe_front #(
  parameter int unsigned MAX_GLYPH_WIDTH  = 8,
  parameter int unsigned MAX_GLYPH_HEIGHT = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire grpe_pkg::cfg_t                  cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [grpe_pkg::ROW_BITS_W-1:0] row_bits,
  input  wire logic [grpe_pkg::COORD_IN_W-1:0] char_x,
  input  wire logic [grpe_pkg::COORD_IN_W-1:0] char_y,
  output logic                                 push,
  output grpe_pkg::cmd_t                       cmd,
  input  wire logic                            q_full
);

  logic [grpe_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [grpe_pkg::GW_W-1:0]     w;
  logic [grpe_pkg::HEFF_W-1:0]   h;
  logic [grpe_pkg::HEFF_W-1:0]   row_inc;
  logic [grpe_pkg::ROW_BITS_W-1:0] masked;
  logic                          dbl;
  logic                          inv;
  logic                          drop;
  logic                          accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // clamp glyph size into the supported range
    if (cfg.gw == '0) begin
      w = grpe_pkg::GW_W'(1);
    end else if (cfg.gw > grpe_pkg::GW_W'(MAX_GLYPH_WIDTH)) begin
      w = grpe_pkg::GW_W'(MAX_GLYPH_WIDTH);
    end else begin
      w = cfg.gw;
    end
    if (cfg.gh == '0) begin
      h = grpe_pkg::HEFF_W'(1);
    end else if ({1'b0, cfg.gh} > grpe_pkg::HEFF_W'(MAX_GLYPH_HEIGHT)) begin
      h = grpe_pkg::HEFF_W'(MAX_GLYPH_HEIGHT);
    end else begin
      h = {1'b0, cfg.gh};
    end

    dbl    = (cfg.mode == grpe_pkg::MODE_DOUBLE);
    inv    = (cfg.mode == grpe_pkg::MODE_INVERTED);
    masked = row_bits & ~(8'hFF >> w);

    row_inc = {1'b0, row_r} + grpe_pkg::HEFF_W'(1);
    row_nxt = (row_inc >= h) ? '0 : row_inc[grpe_pkg::ROW_W-1:0];

    cmd.bits      = masked;
    cmd.cx        = char_x;
    cmd.cy        = char_y;
    cmd.row       = row_r;
    cmd.w         = w;
    cmd.wdim      = dbl ? {w, 1'b0} : {1'b0, w};
    cmd.hdim      = dbl ? {h[grpe_pkg::HEFF_W-2:0], 1'b0} : h;
    cmd.ncx       = grpe_pkg::COORD_W'(char_x) + grpe_pkg::COORD_W'(cmd.wdim);
    cmd.on_color  = inv ? cfg.back : cfg.fore;
    cmd.off_color = inv ? cfg.fore : cfg.back;
    cmd.mode      = cfg.mode;
    cmd.first     = (row_r == '0);

    // empty transparent row past the first gives nothing to draw
    drop = (cfg.mode == grpe_pkg::MODE_TRANSP) && (masked == '0) && !cmd.first;
    push = accept && !drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/grpe_back.sv
`default_nettype none
module grpe_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_nonempty,
  input  wire grpe_pkg::cmd_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output grpe_pkg::res_t      out_res
);

  grpe_pkg::bk_state_t          state_r, state_nxt;
  grpe_pkg::cmd_t               cur_r, cur_nxt;
  logic [grpe_pkg::COL_W-1:0]   col_r, col_nxt;
  logic                         dup_r, dup_nxt;
  logic                         rep_r, rep_nxt;
  logic [grpe_pkg::ROW_BITS_W-1:0] mask_r, mask_nxt;
  logic                         out_valid_r, out_valid_nxt;
  grpe_pkg::res_t               res_r, res_nxt;
  grpe_pkg::res_t               res;
  logic                         adv;
  logic                         is_last;
  logic                         done;
  logic [grpe_pkg::COL_W-1:0]   lead;
  logic [grpe_pkg::ROW_BITS_W-1:0] mask_left;
  logic                         col_end;
  logic                         pix_bit;

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign adv       = !out_valid_r || out_ready;

  always_comb begin
    // leftmost remaining set bit for transparent mode
    lead = '0;
    for (int i = 0; i < grpe_pkg::ROW_BITS_W; i++) begin
      if (mask_r[i]) begin
        lead = grpe_pkg::COL_W'(grpe_pkg::ROW_BITS_W - 1 - i);
      end
    end
    mask_left = mask_r & ~(8'h80 >> lead);
    col_end   = (col_r == grpe_pkg::COL_W'(cur_r.w - grpe_pkg::GW_W'(1)));
    pix_bit   = cur_r.bits[~col_r];

    res = '0;
    res.next_cursor_x = cur_r.ncx;
    is_last = 1'b0;
    case (state_r)
      grpe_pkg::BK_WIN: begin
        res.kind       = grpe_pkg::KIND_WINDOW;
        res.pos_x      = grpe_pkg::COORD_W'(cur_r.cx);
        res.pos_y      = grpe_pkg::COORD_W'(cur_r.cy);
        res.win_width  = cur_r.wdim;
        res.win_height = cur_r.hdim;
        is_last = (cur_r.mode == grpe_pkg::MODE_TRANSP) && (cur_r.bits == '0);
      end
      grpe_pkg::BK_PIX: begin
        if (cur_r.mode == grpe_pkg::MODE_TRANSP) begin
          res.kind        = grpe_pkg::KIND_ADDR;
          res.pos_x       = grpe_pkg::COORD_W'(cur_r.cx) + grpe_pkg::COORD_W'(lead);
          res.pos_y       = grpe_pkg::COORD_W'(cur_r.cy) + grpe_pkg::COORD_W'(cur_r.row);
          res.pixel_color = cur_r.on_color;
          is_last = (mask_left == '0);
        end else begin
          res.kind        = grpe_pkg::KIND_STREAM;
          res.pixel_color = pix_bit ? cur_r.on_color : cur_r.off_color;
          if (cur_r.mode == grpe_pkg::MODE_DOUBLE) begin
            is_last = col_end && dup_r && rep_r;
          end else begin
            is_last = col_end;
          end
        end
      end
      default: begin
        is_last = 1'b0;
      end
    endcase
    res.last = is_last;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    col_nxt       = col_r;
    dup_nxt       = dup_r;
    rep_nxt       = rep_r;
    mask_nxt      = mask_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;

    if (adv) begin
      out_valid_nxt = (state_r != grpe_pkg::BK_IDLE);
      if (state_r != grpe_pkg::BK_IDLE) begin
        res_nxt = res;
      end
    end

    // step through the current row
    case (state_r)
      grpe_pkg::BK_WIN: begin
        if (adv) begin
          state_nxt = grpe_pkg::BK_PIX;
        end
      end
      grpe_pkg::BK_PIX: begin
        if (adv) begin
          if (cur_r.mode == grpe_pkg::MODE_TRANSP) begin
            mask_nxt = mask_left;
          end else if (cur_r.mode == grpe_pkg::MODE_DOUBLE) begin
            dup_nxt = ~dup_r;
            if (dup_r) begin
              if (col_end) begin
                col_nxt = '0;
                rep_nxt = 1'b1;
              end else begin
                col_nxt = col_r + grpe_pkg::COL_W'(1);
              end
            end
          end else begin
            col_nxt = col_r + grpe_pkg::COL_W'(1);
          end
        end
      end
      default: begin
        state_nxt = grpe_pkg::BK_IDLE;
      end
    endcase

    done = (state_r == grpe_pkg::BK_IDLE) || (adv && is_last);
    if (done) begin
      if (q_nonempty) begin
        q_pop     = 1'b1;
        cur_nxt   = q_head;
        state_nxt = q_head.first ? grpe_pkg::BK_WIN : grpe_pkg::BK_PIX;
        col_nxt   = '0;
        dup_nxt   = 1'b0;
        rep_nxt   = 1'b0;
        mask_nxt  = q_head.bits;
      end else begin
        state_nxt = grpe_pkg::BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grpe_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    col_r  <= col_nxt;
    dup_r  <= dup_nxt;
    rep_r  <= rep_nxt;
    mask_r <= mask_nxt;
    res_r  <= res_nxt;
  end

  a_col_in_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grpe_pkg::BK_PIX && cur_r.mode != grpe_pkg::MODE_TRANSP)
      |-> ({1'b0, col_r} < cur_r.w))
    else $error("column counter past glyph width");

  a_transp_has_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grpe_pkg::BK_PIX && cur_r.mode == grpe_pkg::MODE_TRANSP)
      |-> (mask_r != '0))
    else $error("transparent pixel step with no set bit left");

  a_win_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grpe_pkg::BK_WIN) |-> (cur_r.first && cur_r.row == '0))
    else $error("window command on a row other than the first");

  a_load_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && state_r != grpe_pkg::BK_IDLE) |-> (adv && is_last))
    else $error("next row taken before current row finished");

endmodule
`default_nettype wire

FILE: design/glyph_row_pixel_expander.sv
// glyph row pixel expander
// in_* beats carry one glyph bitmap row (bit 7 leftmost) plus the character
// origin; out_* beats carry panel commands: a set-window command on the first
// row of each glyph, then the row's pixels (streamed, or addressed in
// transparent mode). out_tlast marks the final beat caused by one input row.
// cfg_* writes the colors, draw mode and glyph size; a write takes effect
// from the next accepted row.
// an accepted row passes through the queue and the expander state, and its
// first result is registered in the output beat register. the expander
// gives one result beat per cycle unless a valid beat is held by out_tready
// low. a row gives w results (normal, inverted), 4*w (double), the number
// of set bits (transparent), plus one for the window command on the first
// row; an empty transparent row past the first is dropped before the queue.
// a two-entry queue sits between the classifier and the expander, so new
// rows keep being taken while the expander works or the receiver stalls.
// when out_tready is low a valid beat holds and the expander pauses;
// in_tready drops only once the queue is full.
// reset clears the row counter, the queue and the output valid, and loads
// white foreground, black background, normal mode and an 8x8 glyph.
`default_nettype none
module glyph_row_pixel_expander #(
  parameter int unsigned MAX_GLYPH_WIDTH  = 8,
  parameter int unsigned MAX_GLYPH_HEIGHT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: row_bits[7:0], char_x[17:8], char_y[27:18], zero[31:28]
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: pos_x[10:0], pos_y[21:11], win_width[26:22], win_height[32:27],
  //            pixel_color[48:33], next_cursor_x[59:49], zero[63:60]
  output logic [63:0]      out_tdata,
  // out_tuser: kind[1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic [grpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [grpe_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  grpe_pkg::cfg_t cfg_r, cfg_nxt;
  grpe_pkg::cmd_t front_cmd;
  grpe_pkg::cmd_t q_head;
  grpe_pkg::res_t res;
  logic           front_push;
  logic           q_full;
  logic           q_nonempty;
  logic           q_pop;

  // config register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        grpe_pkg::REG_FORE_COLOR:   cfg_nxt.fore = cfg_wdata;
        grpe_pkg::REG_BACK_COLOR:   cfg_nxt.back = cfg_wdata;
        grpe_pkg::REG_DRAW_MODE:    cfg_nxt.mode = grpe_pkg::mode_t'(cfg_wdata[1:0]);
        grpe_pkg::REG_GLYPH_WIDTH:  cfg_nxt.gw   = cfg_wdata[grpe_pkg::GW_W-1:0];
        grpe_pkg::REG_GLYPH_HEIGHT: cfg_nxt.gh   = cfg_wdata[grpe_pkg::GH_W-1:0];
        default:                    cfg_nxt      = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fore <= 16'hFFFF;
      cfg_r.back <= 16'h0000;
      cfg_r.mode <= grpe_pkg::MODE_NORMAL;
      cfg_r.gw   <= grpe_pkg::GW_W'(8);
      cfg_r.gh   <= grpe_pkg::GH_W'(8);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: takes rows, tracks the glyph row, classifies
  grpe_front #(
    .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .row_bits (in_tdata[7:0]),
    .char_x   (in_tdata[17:8]),
    .char_y   (in_tdata[27:18]),
    .push     (front_push),
    .cmd      (front_cmd),
    .q_full   (q_full)
  );

  grpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // back: expands one row into result beats
  grpe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {4'b0000, res.next_cursor_x, res.pixel_color, res.win_height,
                      res.win_width, res.pos_y, res.pos_x};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
`default_nettype wire
